@@ rtl/core/windowed_latency_percentiles_macros.svh @@
// assertion helpers shared by the rtl
`ifndef WINDOWED_LATENCY_PERCENTILES_MACROS_SVH
`define WINDOWED_LATENCY_PERCENTILES_MACROS_SVH

// same-cycle implication, checked out of reset
`define WLP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wlp assertion failed");

// next-cycle implication, checked out of reset
`define WLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wlp assertion failed");

`endif

@@ rtl/core/wlp_pkg.sv @@
package wlp_pkg;

    typedef struct packed {
        logic        kind;
        logic [63:0] start_time;
        logic [63:0] end_time;
    } t_item;

    typedef struct packed {
        logic [63:0] window_start_time;
        logic [63:0] mean_latency;
        logic [63:0] median_latency;
        logic [63:0] p90_latency;
        logic [63:0] p99_latency;
    } t_result;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_DRAIN  = 1'b1;

    localparam logic REG_TIME_LIMIT   = 1'b0;
    localparam logic REG_SAMPLE_LIMIT = 1'b1;

    localparam logic [31:0] TIME_LIMIT_RESET   = 32'd1000000;
    localparam logic [10:0] SAMPLE_LIMIT_RESET = 11'd1000;

    // reciprocal constants: floor(y/10) and floor(y/100) for y up to 4600
    localparam int unsigned DIV10_MUL  = 6554;
    localparam int unsigned DIV10_SH   = 16;
    localparam int unsigned DIV100_MUL = 1311;
    localparam int unsigned DIV100_SH  = 17;

endpackage

@@ rtl/core/wlp_ram.sv @@
module wlp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/wlp_div.sv @@
module wlp_div #(
    parameter int DW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [63:0]   o_quotient
);

    logic [63:0]   r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [6:0]    r_cnt;
    logic          r_done;

    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          qbit;

    // one restoring step per cycle, quotient shifts in from the bottom
    always_comb begin
        shifted = {r_rem, r_q[63]};
        diff    = shifted - {1'b0, r_div};
        qbit    = (shifted >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_cnt  <= 7'd64;
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[62:0], qbit};
            r_rem <= qbit ? diff[DW-1:0] : shifted[DW-1:0];
            r_cnt <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                r_done <= 1'b1;
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

@@ rtl/core/windowed_latency_percentiles.sv @@
// windowed latency statistics
// input channel (i_valid/o_ready, i_item): a sample beat carries start and end
// timestamps; a drain beat closes the open window. samples are taken one per
// cycle while the block is idle and written to the sample memory.
// when a window closes the block goes busy: it insertion-sorts the n stored
// latencies in place through the sample memory (states S_SI, S_SV and S_SC per
// entry, one more S_SC per shifted entry and S_SP per entry moved to the
// front), reads the three percentile entries (states S_P0 to S_P3) and waits
// for the mean divider, which runs beside the sort. o_ready is low from the
// closing beat until the result is loaded.
// output channel (o_valid/i_ready, o_result): one beat per closed window, held
// in an output register; new samples are taken while it waits, and a further
// close stalls only at the point of loading the output register.
// configuration: i_cfg_we writes register i_cfg_idx (0 time limit, 1 sample
// limit); the user must write only while the block is idle (unchecked).
// reset clears the window, the output valid flag and the limits to defaults;
// no clearing pass over the memory is needed.
module windowed_latency_percentiles #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  wlp_pkg::t_item   i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output wlp_pkg::t_result o_result,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [31:0]      i_cfg_wdata
);

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SI, S_SV, S_SC, S_SP, S_P0, S_P1, S_P2, S_P3, S_WAIT
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic [63:0]        r_begin;
    logic [63:0]        r_sum;
    logic [CW-1:0]      r_n;
    logic [CW-1:0]      r_i;
    logic [AW-1:0]      r_j;
    logic [63:0]        r_v;
    logic [63:0]        r_med;
    logic [63:0]        r_p90;
    logic [63:0]        r_p99;
    logic               r_out_valid;
    wlp_pkg::t_result   r_out;
    logic [31:0]        r_lim_time;
    logic [10:0]        r_lim_samp;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [63:0]        mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [63:0]        mem_rdata;

    logic               div_start;
    logic [63:0]        div_dividend;
    logic [CW-1:0]      div_divisor;
    logic               div_done;
    logic [63:0]        div_q;

    logic               acc;
    logic [63:0]        lat;
    logic [63:0]        begin_eff;
    logic [63:0]        elapsed;
    logic [CW-1:0]      new_count;
    logic [31:0]        lim_eff;
    logic               close_now;
    logic               out_load;
    logic [31:0]        q10;
    logic [31:0]        q100;
    logic [AW-1:0]      idx_med;
    logic [AW-1:0]      idx_90;
    logic [AW-1:0]      idx_99;

    assign acc = i_valid && o_ready;

    always_comb begin
        lat       = i_item.end_time - i_item.start_time;
        begin_eff = (r_count == '0) ? i_item.start_time : r_begin;
        elapsed   = i_item.end_time - begin_eff;
        new_count = r_count + CW'(1);
        if (r_lim_samp == '0) begin
            lim_eff = 32'd1;
        end else if (32'(r_lim_samp) > 32'(MAX_SAMPLES)) begin
            lim_eff = 32'(MAX_SAMPLES);
        end else begin
            lim_eff = 32'(r_lim_samp);
        end
        close_now = (32'(new_count) >= lim_eff) || (elapsed > {32'd0, r_lim_time});
        out_load  = (r_state == S_WAIT) && div_done && (!r_out_valid || i_ready);
    end

    // n*9/10 = n - ceil(n/10), n*99/100 = n - ceil(n/100)
    always_comb begin
        q10     = ((32'(r_n) + 32'd9) * wlp_pkg::DIV10_MUL) >> wlp_pkg::DIV10_SH;
        q100    = ((32'(r_n) + 32'd99) * wlp_pkg::DIV100_MUL) >> wlp_pkg::DIV100_SH;
        idx_med = AW'(r_n >> 1);
        idx_90  = AW'(32'(r_n) - q10);
        idx_99  = AW'(32'(r_n) - q100);
    end

    always_comb begin
        mem_we       = 1'b0;
        mem_waddr    = r_j;
        mem_wdata    = r_v;
        mem_raddr    = r_i[AW-1:0];
        div_start    = 1'b0;
        div_dividend = r_sum;
        div_divisor  = r_count;
        case (r_state)
            S_IDLE: begin
                if (acc && i_item.kind == wlp_pkg::KIND_SAMPLE) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_count[AW-1:0];
                    mem_wdata = lat;
                    if (close_now) begin
                        div_start    = 1'b1;
                        div_dividend = r_sum + lat;
                        div_divisor  = new_count;
                    end
                end else if (acc && r_count != '0) begin
                    div_start = 1'b1;
                end
            end
            S_SV: mem_raddr = r_i[AW-1:0] - AW'(1);
            S_SC: begin
                mem_we = 1'b1;
                if (mem_rdata > r_v) begin
                    mem_wdata = mem_rdata;
                    mem_raddr = r_j - AW'(2);
                end
            end
            S_SP: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
            end
            S_P0: mem_raddr = idx_med;
            S_P1: mem_raddr = idx_90;
            S_P2: mem_raddr = idx_99;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_begin     <= '0;
            r_sum       <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
            r_lim_time  <= wlp_pkg::TIME_LIMIT_RESET;
            r_lim_samp  <= wlp_pkg::SAMPLE_LIMIT_RESET;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == wlp_pkg::REG_TIME_LIMIT) begin
                    r_lim_time <= i_cfg_wdata;
                end else begin
                    r_lim_samp <= i_cfg_wdata[10:0];
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc && i_item.kind == wlp_pkg::KIND_SAMPLE) begin
                        r_begin <= begin_eff;
                        if (close_now) begin
                            r_n     <= new_count;
                            r_i     <= CW'(1);
                            r_count <= '0;
                            r_sum   <= '0;
                            r_state <= S_SI;
                        end else begin
                            r_count <= new_count;
                            r_sum   <= r_sum + lat;
                        end
                    end else if (acc && r_count != '0) begin
                        r_n     <= r_count;
                        r_i     <= CW'(1);
                        r_count <= '0;
                        r_sum   <= '0;
                        r_state <= S_SI;
                    end
                end
                S_SI: r_state <= (r_i >= r_n) ? S_P0 : S_SV;
                S_SV: begin
                    r_v     <= mem_rdata;
                    r_j     <= r_i[AW-1:0];
                    r_state <= S_SC;
                end
                S_SC: begin
                    if (mem_rdata > r_v) begin
                        r_j <= r_j - AW'(1);
                        if (r_j == AW'(1)) begin
                            r_state <= S_SP;
                        end
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_SI;
                    end
                end
                S_SP: begin
                    r_i     <= r_i + CW'(1);
                    r_state <= S_SI;
                end
                S_P0: r_state <= S_P1;
                S_P1: begin
                    r_med   <= mem_rdata;
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_p90   <= mem_rdata;
                    r_state <= S_P3;
                end
                S_P3: begin
                    r_p99   <= mem_rdata;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (out_load) begin
                        r_out.window_start_time <= r_begin;
                        r_out.mean_latency      <= div_q;
                        r_out.median_latency    <= r_med;
                        r_out.p90_latency       <= r_p90;
                        r_out.p99_latency       <= r_p99;
                        r_state                 <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    wlp_ram #(
        .WIDTH(64),
        .DEPTH(MAX_SAMPLES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    wlp_div #(
        .DW(CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`include "windowed_latency_percentiles_macros.svh"

    `WLP_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count < CW'(MAX_SAMPLES))
    `WLP_ASSERT_SAME(a_busy_nonempty, i_clk, i_rst_n, r_state != S_IDLE, r_n != '0)
    `WLP_ASSERT_SAME(a_insert_below, i_clk, i_rst_n, r_state == S_SC, CW'(r_j) <= r_i)
    `WLP_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, out_load, o_valid && r_state == S_IDLE)

endmodule
